### src/sta_pkg.sv
// Shared types, sizes and command codes of the slot table allocator.
`timescale 1ns / 1ps

package sta_pkg;

   localparam int SLOTS        = 512;
   localparam int ENTITY_COUNT = 1024;

   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int OWNER_W  = $clog2(ENTITY_COUNT);
   localparam int COUNT_W  = $clog2(SLOTS + 1);
   localparam int WORD_W   = 32;
   localparam int BIT_W    = $clog2(WORD_W);
   localparam int WORDS    = (SLOTS + WORD_W - 1) / WORD_W;
   localparam int SCAN_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int RADIUS_W = 33;

   localparam logic [2:0] CMD_ADD         = 3'd0;
   localparam logic [2:0] CMD_REMOVE      = 3'd1;
   localparam logic [2:0] CMD_ENABLE      = 3'd2;
   localparam logic [2:0] CMD_SET_MASK    = 3'd3;
   localparam logic [2:0] CMD_CLEAR_OWNER = 3'd4;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [31:0]        slot_index;
      logic               enable_flag;
      logic [31:0]        team_bits;
      logic [31:0]        owner_entity;
      logic signed [31:0] radius;
      logic signed [31:0] axis_span;
      logic signed [31:0] timeout;
      logic [31:0]        current_time;
   } req_type;

   typedef struct packed {
      logic [8:0] result_slot;
      logic       ok;
      logic [9:0] removed_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic scan;
      logic walk;
      logic finish;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic add_go;
      logic clear_go;
      logic scan_hit;
      logic scan_end;
      logic walk_last;
      logic rsp_free;
   } ctl_sts_type;

endpackage

### src/sta_ctrl.sv
// Command sequencer of the slot table allocator.
`timescale 1ns / 1ps

module sta_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sta_pkg::ctl_sts_type ctl_sts,
   output sta_pkg::ctl_cmd_type ctl_cmd
);
   import sta_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (ctl_sts.add_go) state_in = ST_SCAN;
            else if (ctl_sts.clear_go) state_in = ST_WALK;
            else state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (ctl_sts.scan_hit || ctl_sts.scan_end) state_in = ST_DONE;
         end
         ST_WALK: begin
            if (ctl_sts.walk_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            // last owner compare lands here
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (ctl_sts.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      ctl_cmd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall    = 1'b0;
            ctl_cmd.load = req_valid;
         end
         ST_EXEC:  ctl_cmd.exec = 1'b1;
         ST_SCAN:  ctl_cmd.scan = 1'b1;
         ST_WALK:  ctl_cmd.walk = 1'b1;
         ST_DRAIN: ;
         ST_DONE:  ctl_cmd.finish = ctl_sts.rsp_free;
         default: ;
      endcase
   end

endmodule

### src/sta_datapath.sv
// Slot storage, free-slot search, owner walk and result register.
`timescale 1ns / 1ps

module sta_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  sta_pkg::ctl_cmd_type ctl_cmd,
   output sta_pkg::ctl_sts_type ctl_sts,
   input  sta_pkg::req_type     req_data,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output sta_pkg::rsp_type     rsp_data
);
   import sta_pkg::*;

   req_type req_ff;

   logic [SLOTS-1:0] used_ff;

   // per-slot storage; owner entry is {tagged, number}
   logic [OWNER_W:0]          own_mem  [SLOTS];
   logic                      act_mem  [SLOTS];
   logic [31:0]               team_mem [SLOTS];
   logic [32+RADIUS_W-1:0]    meta_mem [SLOTS];
   logic [OWNER_W:0]          own_rd_ff;

   logic [SCAN_W-1:0]  scan_ff;
   logic [SLOT_W-1:0]  walk_ff;
   logic [SLOT_W-1:0]  chk_idx_ff;
   logic               chk_vld_ff;

   logic [SLOT_W-1:0]  res_slot_ff;
   logic               res_ok_ff;
   logic [COUNT_W-1:0] res_count_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic                      add_go;
   logic                      idx_hit;
   logic                      tag_ok;
   logic [31:0]               expiry;
   logic [RADIUS_W-1:0]       bound;
   logic [WORDS*WORD_W-1:0]   used_pad;
   logic [WORD_W-1:0]         free_word;
   logic [BIT_W-1:0]          hit_bit;
   logic                      scan_hit;
   logic [SLOT_W-1:0]         alloc_idx;
   logic                      chk_match;

   logic                      used_we;
   logic                      used_wval;
   logic [SLOT_W-1:0]         wr_addr;
   logic                      own_we;
   logic [OWNER_W:0]          own_wdata;
   logic                      act_we;
   logic                      act_wdata;
   logic                      team_we;
   logic [31:0]               team_wdata;
   logic                      meta_we;
   logic [32+RADIUS_W-1:0]    meta_wdata;

   // ---- decode of the held item ----
   assign add_go  = (req_ff.cmd == CMD_ADD) && (req_ff.radius > 32'sd0);
   assign idx_hit = (req_ff.slot_index < 32'(SLOTS))
                    && used_ff[req_ff.slot_index[SLOT_W-1:0]];
   assign tag_ok  = req_ff.owner_entity < 32'(ENTITY_COUNT);
   assign expiry  = (req_ff.timeout > 32'sd0)
                    ? req_ff.current_time + $unsigned(req_ff.timeout) : 32'd0;
   // radius + floor(axis / 2), sign-extended to 33 bits
   assign bound   = {req_ff.radius[31], req_ff.radius}
                    + {{2{req_ff.axis_span[31]}}, req_ff.axis_span[31:1]};

   // ---- first-fit search, one bitmap word per cycle ----
   always_comb begin
      used_pad = '1;  // slots past the end look taken
      used_pad[SLOTS-1:0] = used_ff;
   end

   assign free_word = ~used_pad[scan_ff*WORD_W +: WORD_W];
   assign scan_hit  = |free_word;

   always_comb begin
      hit_bit = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (free_word[b]) hit_bit = BIT_W'(b);
      end
   end

   assign alloc_idx = SLOT_W'({scan_ff, hit_bit});

   // ---- owner walk compare, one stage behind the read ----
   assign chk_match = chk_vld_ff && used_ff[chk_idx_ff] && own_rd_ff[OWNER_W]
                      && (32'(own_rd_ff[OWNER_W-1:0]) == req_ff.owner_entity);

   // ---- write port select ----
   always_comb begin
      wr_addr    = '0;
      used_we    = 1'b0;
      used_wval  = 1'b0;
      own_we     = 1'b0;
      own_wdata  = '0;
      act_we     = 1'b0;
      act_wdata  = 1'b0;
      team_we    = 1'b0;
      team_wdata = '0;
      meta_we    = 1'b0;
      meta_wdata = '0;
      if (chk_match) begin
         wr_addr = chk_idx_ff;
         used_we = 1'b1;
         own_we  = 1'b1;
         act_we  = 1'b1;
         team_we = 1'b1;
         meta_we = 1'b1;
      end else if (ctl_cmd.scan && scan_hit) begin
         wr_addr    = alloc_idx;
         used_we    = 1'b1;
         used_wval  = 1'b1;
         own_we     = 1'b1;
         own_wdata  = tag_ok ? {1'b1, req_ff.owner_entity[OWNER_W-1:0]} : '0;
         act_we     = 1'b1;
         act_wdata  = 1'b1;
         team_we    = 1'b1;
         team_wdata = req_ff.team_bits;
         meta_we    = 1'b1;
         meta_wdata = {expiry, bound};
      end else if (ctl_cmd.exec && idx_hit) begin
         wr_addr = req_ff.slot_index[SLOT_W-1:0];
         case (req_ff.cmd)
            CMD_REMOVE: begin
               used_we = 1'b1;
               own_we  = 1'b1;
               act_we  = 1'b1;
               team_we = 1'b1;
               meta_we = 1'b1;
            end
            CMD_ENABLE: begin
               act_we    = 1'b1;
               act_wdata = req_ff.enable_flag;
            end
            CMD_SET_MASK: begin
               team_we    = 1'b1;
               team_wdata = req_ff.team_bits;
            end
            default: ;
         endcase
      end
   end

   // ---- storage ----
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (used_we) begin
         used_ff[wr_addr] <= used_wval;
      end
   end

   always_ff @(posedge clock) begin
      if (own_we) own_mem[wr_addr] <= own_wdata;
      own_rd_ff <= own_mem[walk_ff];
   end

   always_ff @(posedge clock) begin
      if (act_we) act_mem[wr_addr] <= act_wdata;
      if (team_we) team_mem[wr_addr] <= team_wdata;
      if (meta_we) meta_mem[wr_addr] <= meta_wdata;
   end

   // ---- item, counters ----
   always_ff @(posedge clock) begin
      if (ctl_cmd.load) req_ff <= req_data;
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.load) begin
         scan_ff <= '0;
         walk_ff <= '0;
      end else begin
         if (ctl_cmd.scan && !scan_hit) scan_ff <= scan_ff + 1'b1;
         if (ctl_cmd.walk) walk_ff <= walk_ff + 1'b1;
      end
      chk_idx_ff <= walk_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_vld_ff <= 1'b0;
      end else begin
         chk_vld_ff <= ctl_cmd.walk;
      end
   end

   // ---- result ----
   always_ff @(posedge clock) begin
      if (ctl_cmd.load) begin
         res_slot_ff  <= '0;
         res_ok_ff    <= 1'b0;
         res_count_ff <= '0;
      end else begin
         if (ctl_cmd.exec) begin
            case (req_ff.cmd) inside
               CMD_REMOVE, CMD_ENABLE, CMD_SET_MASK: res_ok_ff <= idx_hit;
               CMD_CLEAR_OWNER:                      res_ok_ff <= 1'b1;
               default: ;
            endcase
         end
         if (ctl_cmd.scan && scan_hit) begin
            res_slot_ff <= alloc_idx;
            res_ok_ff   <= 1'b1;
         end
         if (chk_match) res_count_ff <= res_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl_cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.finish) begin
         rsp_data_ff.result_slot   <= 9'(res_slot_ff);
         rsp_data_ff.ok            <= res_ok_ff;
         rsp_data_ff.removed_count <= 10'(res_count_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign ctl_sts.add_go    = add_go;
   assign ctl_sts.clear_go  = (req_ff.cmd == CMD_CLEAR_OWNER);
   assign ctl_sts.scan_hit  = scan_hit;
   assign ctl_sts.scan_end  = (scan_ff == SCAN_W'(WORDS - 1));
   assign ctl_sts.walk_last = (walk_ff == SLOT_W'(SLOTS - 1));
   assign ctl_sts.rsp_free  = !rsp_valid_ff || !rsp_stall;

endmodule

### src/slot_table_allocator_with_owner.sv
// Top level of the first-fit slot table allocator with owner tags.
//
//   channel  ports                        moves
//   req      req_valid req_stall req_data one command item (sta_pkg::req_type)
//   rsp      rsp_valid rsp_stall rsp_data one result item  (sta_pkg::rsp_type)
//
// Every item is taken in idle and decoded in exec; done hands its result to the output register.
// remove, enable, set_mask, unknown codes and an add with radius <= 0 go from exec to done.
// add scans the used bitmap, one 32-slot word a cycle, up to SLOTS/32 words, until a free slot.
// clear_owner walks all SLOTS slots, one owner memory read per slot, then drains the last compare.
// Reset clears the used bitmap at once; no clearing pass is run.
// A stalled result holds in the output register; the next item is still taken,
// and its result waits in the datapath, input stalled, until the register frees.
`timescale 1ns / 1ps

module slot_table_allocator_with_owner (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sta_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sta_pkg::rsp_type rsp_data
);
   import sta_pkg::*;

   ctl_cmd_type ctl_cmd;
   ctl_sts_type ctl_sts;

   sta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .ctl_sts   (ctl_sts),
      .ctl_cmd   (ctl_cmd)
   );

   sta_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl_cmd   (ctl_cmd),
      .ctl_sts   (ctl_sts),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### src/sta_checker.sv
// Port-level checks of the slot table allocator, bound to the top level.
`timescale 1ns / 1ps

module sta_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input sta_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sta_pkg::rsp_type rsp_data
);
   import sta_pkg::*;

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // one item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while previous one in progress");

   // only clear_owner reports a count, and it always succeeds
   a_count_needs_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.removed_count != 10'd0) |-> rsp_data.ok)
      else $error("removed count without success");

   // a slot index is only reported by a successful add
   a_slot_needs_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.result_slot != 9'd0) |-> rsp_data.ok
         && (rsp_data.removed_count == 10'd0))
      else $error("slot index on a failed or counting result");

endmodule

bind slot_table_allocator_with_owner sta_checker u_sta_checker (.*);
